@@ hdl/fs4_halfband_ddc_core_defines.svh @@
// Assertion helpers shared by the RTL files.
`ifndef FS4_HALFBAND_DDC_CORE_DEFINES_SVH
`define FS4_HALFBAND_DDC_CORE_DEFINES_SVH

// Same-cycle implication, checked on clk_i, off while rst_ni is low.
`define FHD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i, off while rst_ni is low.
`define FHD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/fhd_pkg.sv @@
package fhd_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int VAL_W      = 16;
  // working width for rounding and saturation helpers
  localparam int RND_W      = 48;

  localparam logic signed [RND_W-1:0] SAT_MAX  = 48'sd32767;
  localparam logic signed [RND_W-1:0] SAT_MIN  = -48'sd32768;
  localparam logic signed [RND_W-1:0] RND_BIAS = 48'sd16384;

  localparam logic signed [15:0] CENTER_RESET = 16'sd16384;
  localparam logic [15:0]        ALPHA_RESET  = 16'd655;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEFF_A  = 3'd0,
    REG_COEFF_B  = 3'd1,
    REG_COEFF_C  = 3'd2,
    REG_COEFF_D  = 3'd3,
    REG_CENTER   = 3'd4,
    REG_ALPHA    = 3'd5,
    REG_MIDPOINT = 3'd6
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DCMUL,
    ST_DCUPD,
    ST_FIR,
    ST_DRAIN,
    ST_QMUL,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    MUL_DC,
    MUL_Q,
    MUL_FIR
  } mul_sel_e;

  typedef struct packed {
    logic       load_in;
    logic       prep;
    logic       mul_en;
    mul_sel_e   mul_sel;
    logic       dc_upd;
    logic       acc_clr;
    logic       fir_issue;
    logic       load_out;
    logic [1:0] phase;
  } dp_cmd_t;

  typedef struct packed {
    logic fir_busy;
    logic out_free;
  } dp_status_t;

  function automatic logic signed [VAL_W-1:0] sat16(input logic signed [RND_W-1:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > SAT_MAX) begin
      r = 16'sh7fff;
    end else if (v < SAT_MIN) begin
      r = 16'sh8000;
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

  // add half an LSB, floor-shift by 15, saturate
  function automatic logic signed [VAL_W-1:0] round_q15(input logic signed [RND_W-1:0] v);
    logic signed [RND_W-1:0] t;
    t = (v + RND_BIAS) >>> 15;
    return sat16(t);
  endfunction

endpackage

@@ hdl/fhd_ram.sv @@
module fhd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

@@ hdl/fhd_ctrl.sv @@
`include "fs4_halfband_ddc_core_defines.svh"

module fhd_ctrl #(
  parameter int FIR_TAPS = 32,
  localparam int PAIRS  = FIR_TAPS / 2,
  localparam int PIDX_W = $clog2(PAIRS)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  input  fhd_pkg::dp_status_t status_i,
  output fhd_pkg::dp_cmd_t    cmd_o,
  output logic [PIDX_W-1:0]   pair_idx_o
);

  import fhd_pkg::*;

  localparam logic [PIDX_W-1:0] LAST_PAIR = PIDX_W'(PAIRS - 1);

  state_e            state_q, state_d;
  logic [1:0]        phase_q, phase_d;
  logic [PIDX_W-1:0] pidx_q, pidx_d;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (s_valid_i) state_d = ST_PREP;
      ST_PREP:  state_d = ST_DCMUL;
      ST_DCMUL: state_d = ST_DCUPD;
      ST_DCUPD: state_d = phase_q[0] ? ST_QMUL : ST_FIR;
      ST_FIR:   if (pidx_q == LAST_PAIR) state_d = ST_DRAIN;
      ST_DRAIN: if (!status_i.fir_busy) state_d = ST_DONE;
      ST_QMUL:  state_d = ST_DONE;
      ST_DONE:  if (status_i.out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o           = '0;
    cmd_o.mul_sel   = MUL_DC;
    cmd_o.phase     = phase_q;
    s_ready_o       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o     = 1'b1;
        cmd_o.load_in = s_valid_i;
      end
      ST_PREP:  cmd_o.prep = 1'b1;
      ST_DCMUL: cmd_o.mul_en = 1'b1;
      ST_DCUPD: begin
        cmd_o.dc_upd  = 1'b1;
        cmd_o.acc_clr = 1'b1;
      end
      ST_FIR: begin
        cmd_o.fir_issue = 1'b1;
        cmd_o.mul_sel   = MUL_FIR;
      end
      ST_DRAIN: cmd_o.mul_sel = MUL_FIR;
      ST_QMUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_Q;
      end
      ST_DONE:  cmd_o.load_out = status_i.out_free;
      default: ;
    endcase
  end

  assign pair_idx_o = pidx_q;

  always_comb begin
    pidx_d  = (state_q == ST_FIR) ? pidx_q + 1'b1 : '0;
    phase_d = cmd_o.load_out ? phase_q + 2'd1 : phase_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= '0;
      pidx_q  <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      pidx_q  <= pidx_d;
    end
  end

  `FHD_ASSERT_NEXT(a_accept_then_prep, s_valid_i && s_ready_o, cmd_o.prep, "prep did not follow accept")
  `FHD_ASSERT_NOW(a_issue_not_load, cmd_o.fir_issue, !cmd_o.load_out, "result loaded while FIR issues")
  `FHD_ASSERT_NEXT(a_phase_step, cmd_o.load_out, phase_q == $past(phase_q) + 2'd1, "phase did not advance")

endmodule

@@ hdl/fhd_datapath.sv @@
`include "fs4_halfband_ddc_core_defines.svh"

module fhd_datapath #(
  parameter int FIR_TAPS    = 32,
  parameter int DELAY_DEPTH = 16,
  parameter int SAMPLE_BITS = 12,
  localparam int PAIRS  = FIR_TAPS / 2,
  localparam int PIDX_W = $clog2(PAIRS),
  localparam int AW     = $clog2(FIR_TAPS),
  localparam int DW     = $clog2(DELAY_DEPTH),
  localparam int SHIFT  = 16 - SAMPLE_BITS,
  localparam int ACC_W  = 34 + PIDX_W
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fhd_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [fhd_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic [SAMPLE_BITS-1:0]              adc_sample_i,
  input  fhd_pkg::dp_cmd_t                    cmd_i,
  input  logic [PIDX_W-1:0]                   pair_idx_i,
  output fhd_pkg::dp_status_t                 status_o,
  output logic signed [fhd_pkg::VAL_W-1:0]    out_value_o,
  output logic                                out_is_q_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i
);

  import fhd_pkg::*;

  // configuration
  logic [63:0]             coeff_word_q [4];
  logic signed [15:0]      center_q;
  logic [15:0]             alpha_q;
  logic [SAMPLE_BITS-1:0]  mid_q;
  logic signed [15:0]      coeff_arr [16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < 4; w++) coeff_word_q[w] <= '0;
      center_q <= CENTER_RESET;
      alpha_q  <= ALPHA_RESET;
      mid_q    <= SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_COEFF_A:  coeff_word_q[0] <= cfg_data_i;
        REG_COEFF_B:  coeff_word_q[1] <= cfg_data_i;
        REG_COEFF_C:  coeff_word_q[2] <= cfg_data_i;
        REG_COEFF_D:  coeff_word_q[3] <= cfg_data_i;
        REG_CENTER:   center_q <= cfg_data_i[15:0];
        REG_ALPHA:    alpha_q  <= cfg_data_i[15:0];
        REG_MIDPOINT: mid_q    <= cfg_data_i[SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      coeff_arr[k] = coeff_word_q[k >> 2][16*(k & 3) +: 16];
    end
  end

  // sample capture and residual
  logic [SAMPLE_BITS-1:0]     code_q;
  logic signed [SAMPLE_BITS:0] diff;
  logic signed [16:0]         diff_x;
  logic signed [16:0]         samp_w;
  logic signed [15:0]         sample;
  logic signed [17:0]         resid_w;
  logic signed [15:0]         resid, routed;
  logic signed [15:0]         resid_q, routed_q;
  logic signed [31:0]         dc_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) code_q <= adc_sample_i;
  end

  always_comb begin
    diff    = $signed({1'b0, code_q}) - $signed({1'b0, mid_q});
    diff_x  = 17'(diff);
    samp_w  = diff_x <<< SHIFT;
    sample  = sat16(RND_W'(samp_w));
    resid_w = 18'(sample) - 18'($signed(dc_q[31:16]));
    resid   = sat16(RND_W'(resid_w));
    if (!cmd_i.phase[1]) begin
      routed = (resid == 16'sh8000) ? 16'sh7fff : -resid;
    end else begin
      routed = resid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      resid_q  <= resid;
      routed_q <= routed;
    end
  end

  // FIR history
  logic [AW-1:0]        wpos_q;
  logic [FIR_TAPS-1:0]  hist_vld_q;
  logic                 hist_we;
  logic [AW:0]          lo_sum, hi_sum;
  logic [AW-1:0]        lo_addr, hi_addr;
  logic [15:0]          rd_lo, rd_hi;

  assign hist_we = cmd_i.prep && !cmd_i.phase[0];

  always_comb begin
    lo_sum = (AW+1)'(wpos_q) + (AW+1)'(pair_idx_i) + (AW+1)'(1);
    if (lo_sum >= (AW+1)'(FIR_TAPS)) lo_sum = lo_sum - (AW+1)'(FIR_TAPS);
    hi_sum = (AW+1)'(wpos_q) + (AW+1)'(FIR_TAPS) - (AW+1)'(pair_idx_i);
    if (hi_sum >= (AW+1)'(FIR_TAPS)) hi_sum = hi_sum - (AW+1)'(FIR_TAPS);
    lo_addr = lo_sum[AW-1:0];
    hi_addr = hi_sum[AW-1:0];
  end

  fhd_ram #(
    .WIDTH (16),
    .DEPTH (FIR_TAPS)
  ) u_hist_ram (
    .clk_i     (clk_i),
    .we_i      (hist_we),
    .waddr_i   (wpos_q),
    .wdata_i   (routed),
    .raddr_a_i (lo_addr),
    .raddr_b_i (hi_addr),
    .rdata_a_o (rd_lo),
    .rdata_b_o (rd_hi)
  );

  // MAC pipeline: read, pair sum, multiply, accumulate
  logic                     v1_q, v2_q, v3_q;
  logic                     vlo_q, vhi_q;
  logic [PIDX_W-1:0]        j1_q;
  logic signed [16:0]       pair_sum_q;
  logic signed [15:0]       coef_q;
  logic signed [15:0]       tap_lo, tap_hi;
  logic signed [ACC_W-1:0]  acc_q;

  always_comb begin
    tap_lo = vlo_q ? $signed(rd_lo) : 16'sd0;
    tap_hi = vhi_q ? $signed(rd_hi) : 16'sd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_vld_q <= '0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      v3_q       <= 1'b0;
    end else begin
      if (hist_we) hist_vld_q[wpos_q] <= 1'b1;
      v1_q <= cmd_i.fir_issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fir_issue) begin
      vlo_q <= hist_vld_q[lo_addr];
      vhi_q <= hist_vld_q[hi_addr];
      j1_q  <= pair_idx_i;
    end
    if (v1_q) begin
      pair_sum_q <= 17'(tap_lo) + 17'(tap_hi);
      coef_q     <= (32'(j1_q) < 32'd16) ? coeff_arr[4'(j1_q)] : 16'sd0;
    end
  end

  // shared multiplier
  logic signed [17:0] mul_a, mul_b;
  logic signed [35:0] prod_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (v2_q) begin
      mul_a = 18'(pair_sum_q);
      mul_b = 18'(coef_q);
    end else begin
      case (cmd_i.mul_sel)
        MUL_DC: begin
          mul_a = $signed({2'b00, alpha_q});
          mul_b = 18'(resid_q);
        end
        MUL_Q: begin
          mul_a = 18'(routed_q);
          mul_b = 18'(center_q);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en || v2_q) prod_q <= mul_a * mul_b;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (v3_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // DC estimate, saturated to 32 bits
  logic signed [35:0] est;
  logic signed [31:0] est_sat;

  always_comb begin
    est = 36'(dc_q) + prod_q;
    if (est > 36'sd2147483647) begin
      est_sat = 32'sh7fffffff;
    end else if (est < -36'sd2147483648) begin
      est_sat = 32'sh80000000;
    end else begin
      est_sat = est[31:0];
    end
  end

  // Q delay line
  logic signed [15:0] delay_q [DELAY_DEPTH];
  logic [DW-1:0]      qpos_q;
  logic signed [15:0] q_scaled;
  logic signed [15:0] i_result;

  assign q_scaled = round_q15(RND_W'(prod_q));
  assign i_result = round_q15(RND_W'(acc_q));

  // output register
  logic signed [15:0] out_value_q;
  logic               out_is_q_q;
  logic               out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_q        <= '0;
      wpos_q      <= '0;
      qpos_q      <= '0;
      out_valid_q <= 1'b0;
      for (int d = 0; d < DELAY_DEPTH; d++) delay_q[d] <= '0;
    end else begin
      if (cmd_i.dc_upd) dc_q <= est_sat;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
        if (cmd_i.phase[0]) begin
          delay_q[qpos_q] <= q_scaled;
          qpos_q <= (qpos_q == DW'(DELAY_DEPTH - 1)) ? '0 : qpos_q + 1'b1;
        end else begin
          wpos_q <= (wpos_q == AW'(FIR_TAPS - 1)) ? '0 : wpos_q + 1'b1;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_value_q <= cmd_i.phase[0] ? delay_q[qpos_q] : i_result;
      out_is_q_q  <= cmd_i.phase[0];
    end
  end

  assign out_value_o       = out_value_q;
  assign out_is_q_o        = out_is_q_q;
  assign out_valid_o       = out_valid_q;
  assign status_o.fir_busy = v1_q | v2_q | v3_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  `FHD_ASSERT_NOW(a_load_when_free, cmd_i.load_out, status_o.out_free, "result overwrote a waiting one")
  `FHD_ASSERT_NOW(a_clear_when_drained, cmd_i.acc_clr, !(v1_q || v2_q || v3_q), "accumulator cleared mid MAC")
  `FHD_ASSERT_NOW(a_no_mul_clash, cmd_i.mul_en, !v2_q, "multiplier claimed twice")

endmodule

@@ hdl/fs4_halfband_ddc_core.sv @@
// channel   | dir | handshake                    | payload
// ----------+-----+------------------------------+------------------------------------
// s_axis    | in  | s_axis_tvalid / s_axis_tready | tdata: adc_sample
// m_axis    | out | m_axis_tvalid / m_axis_tready | tdata: out_value; tuser: out_is_q
// cfg       | in  | cfg_we_i (no back-pressure)   | cfg_idx_i, cfg_data_i
//
// One transaction at a time. A Q sample (odd phase) steps through PREP, DCMUL, DCUPD
// and QMUL from accept to result load; an I sample (even phase) through PREP, DCMUL,
// DCUPD, FIR and DRAIN, where the single shared 18x18 multiplier does one pair MAC
// per cycle in its read/sum/multiply/accumulate pipeline. Reset is asynchronous
// active low and clears control, config, DC, pointer, flag and delay-line state,
// not the history RAM or data registers; no clearing pass is needed (history validity
// is held in per-entry flags). The result register lets the next sample be accepted
// while the last result waits on m_axis_tready; completion stalls only if it is full.
module fs4_halfband_ddc_core #(
  parameter int FIR_TAPS    = 32,
  parameter int DELAY_DEPTH = 16,
  parameter int SAMPLE_BITS = 12,
  localparam int PIDX_W     = $clog2(FIR_TAPS / 2),
  localparam int IN_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration writes
  input  logic                            cfg_we_i,
  input  logic [fhd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [fhd_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // sample stream in
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [IN_TDATA_W-1:0]           s_axis_tdata,  // [SAMPLE_BITS-1:0] adc_sample
  // I/Q stream out
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [fhd_pkg::VAL_W-1:0]       m_axis_tdata,  // [15:0] out_value
  output logic [0:0]                      m_axis_tuser   // [0] out_is_q
);

  import fhd_pkg::*;

  dp_cmd_t            cmd;
  dp_status_t         status;
  logic [PIDX_W-1:0]  pair_idx;
  logic signed [15:0] out_value;
  logic               out_is_q;

  fhd_ctrl #(
    .FIR_TAPS (FIR_TAPS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd),
    .pair_idx_o (pair_idx)
  );

  fhd_datapath #(
    .FIR_TAPS    (FIR_TAPS),
    .DELAY_DEPTH (DELAY_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .adc_sample_i (s_axis_tdata[SAMPLE_BITS-1:0]),
    .cmd_i        (cmd),
    .pair_idx_i   (pair_idx),
    .status_o     (status),
    .out_value_o  (out_value),
    .out_is_q_o   (out_is_q),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready)
  );

  assign m_axis_tdata    = out_value;
  assign m_axis_tuser[0] = out_is_q;

endmodule
